// ===== hw/rtl/dlc_pkg.sv =====
// Shared types, codes and field widths for the display list coprocessor.
package dlc_pkg;

	localparam int unsigned ADDRESS_BITS_DEF = 19;
	localparam int unsigned PC_OUT_W         = 19;
	localparam int unsigned CFG_DATA_W       = 19;
	localparam int unsigned CFG_INDEX_W      = 2;
	localparam int unsigned IN_DATA_W        = 40;
	localparam int unsigned IN_USER_W        = 2;
	localparam int unsigned OUT_DATA_W       = 56;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_VSYNC = 2'd1,
		OP_JUMP1 = 2'd2,
		OP_JUMP2 = 2'd3
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LIST1  = 2'd0,
		CFG_LIST2  = 2'd1,
		CFG_DANGER = 2'd2,
		CFG_DMA    = 2'd3
	} cfg_index_t;

	typedef enum logic [5:0] {
		ST_HALT    = 6'b000001,
		ST_REQ     = 6'b000010,
		ST_FETCH   = 6'b000100,
		ST_MOVE    = 6'b001000,
		ST_WSKIP   = 6'b010000,
		ST_WAITING = 6'b100000
	} mode_t;

	localparam logic [2:0] MODE_HALT    = 3'd0;
	localparam logic [2:0] MODE_REQ     = 3'd1;
	localparam logic [2:0] MODE_FETCH   = 3'd2;
	localparam logic [2:0] MODE_MOVE    = 3'd3;
	localparam logic [2:0] MODE_WSKIP   = 3'd4;
	localparam logic [2:0] MODE_WAITING = 3'd5;

	localparam logic [7:0] PROT_LIMIT        = 8'h80;
	localparam logic [7:0] PROT_LIMIT_DANGER = 8'h40;

	function automatic logic [2:0] mode_code(input mode_t m);
		case (m)
			ST_HALT:    mode_code = MODE_HALT;
			ST_REQ:     mode_code = MODE_REQ;
			ST_FETCH:   mode_code = MODE_FETCH;
			ST_MOVE:    mode_code = MODE_MOVE;
			ST_WSKIP:   mode_code = MODE_WSKIP;
			ST_WAITING: mode_code = MODE_WAITING;
			default:    mode_code = MODE_HALT;
		endcase
	endfunction

	// masked beam comparator: vertical first, horizontal decides on a tie
	function automatic logic beam_reached(
		input logic [15:0] pos_word,
		input logic [15:0] mask_word,
		input logic [7:0]  bv,
		input logic [7:0]  bh
	);
		logic [7:0] vm;
		logic [7:0] hm;
		logic [7:0] vb;
		logic [7:0] vw;
		logic [7:0] hb;
		logic [7:0] hw;
		vm = {1'b1, mask_word[14:8]};
		hm = {mask_word[7:1], 1'b0};
		vb = bv & vm;
		vw = pos_word[15:8] & vm;
		hb = bh & hm;
		hw = pos_word[7:0] & hm;
		beam_reached = (vb > vw) || ((vb == vw) && (hb >= hw));
	endfunction

endpackage

// ===== hw/rtl/display_list_coprocessor.sv =====
// Display list coprocessor: instruction sequencer with registered result word.
//
// Each input word is a bus-slot tick, a vsync or a jump, selected by s_axis_tuser,
// and yields exactly one result word. The sequencer state and the result register
// update in the same cycle the input word is taken, so one word is accepted every
// cycle; the only stall comes from the result register, which frees up when
// m_axis_tready takes its word. The result word is registered and is offered in the cycle after acceptance.
// Configuration (list starts, danger and DMA enables) is written through cfg_we.
module display_list_coprocessor #(
	parameter int unsigned ADDRESS_BITS = dlc_pkg::ADDRESS_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// bus_free[0], mem_word[16:1], beam_v[25:17], beam_h[33:26], zero fill
	input  logic [dlc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// opcode[1:0]
	input  logic [dlc_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// reg_write_valid[0], reg_write_addr[9:1], reg_write_data[25:10],
	// next_read_address[44:26], sequencer_mode[47:45], skip_pending[48], zero fill
	output logic [dlc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [dlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dlc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dlc_pkg::*;

	localparam int unsigned EXT_W = (ADDRESS_BITS > PC_OUT_W) ? ADDRESS_BITS : PC_OUT_W;

	logic [ADDRESS_BITS-1:0] list1_q, list2_q;
	logic                    danger_q, dma_q;

	mode_t                   mode_q, mode_d;
	logic [ADDRESS_BITS-1:0] pc_q, pc_d;
	logic [15:0]             first_q, first_d;
	logic [15:0]             second_q, second_d;
	logic                    skip_q, skip_d;

	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	logic                    accept;
	opcode_t                 op;
	logic                    bus_free;
	logic [15:0]             mem_word;
	logic [8:0]              beam_v;
	logic [7:0]              beam_h;

	logic                    wv;
	logic [8:0]              wa;
	logic [15:0]             wd;
	logic                    reached;
	logic [15:0]             mask_src;
	logic [8:0]              move_ra;
	logic [7:0]              limit;
	logic [ADDRESS_BITS-1:0] pc_inc;
	logic [EXT_W-1:0]        cfg_ext;
	logic [ADDRESS_BITS-1:0] cfg_addr;
	logic [EXT_W-1:0]        pc_ext;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign op       = opcode_t'(s_axis_tuser);
	assign bus_free = s_axis_tdata[0];
	assign mem_word = s_axis_tdata[16:1];
	assign beam_v   = s_axis_tdata[25:17];
	assign beam_h   = s_axis_tdata[33:26];

	// list starts keep only even addresses inside the address space
	assign cfg_ext  = EXT_W'(cfg_data);
	assign cfg_addr = {cfg_ext[ADDRESS_BITS-1:1], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list1_q  <= '0;
			list2_q  <= '0;
			danger_q <= 1'b0;
			dma_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_LIST1:  list1_q  <= cfg_addr;
				CFG_LIST2:  list2_q  <= cfg_addr;
				CFG_DANGER: danger_q <= cfg_data[0];
				CFG_DMA:    dma_q    <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// skip compares against the mask word arriving now; waiting uses the stored one
	assign mask_src = (mode_q == ST_WSKIP) ? mem_word : second_q;
	assign reached  = beam_reached(first_q, mask_src, beam_v[7:0], beam_h);
	assign move_ra  = {first_q[8:1], 1'b0};
	assign limit    = danger_q ? PROT_LIMIT_DANGER : PROT_LIMIT;
	assign pc_inc   = pc_q + ADDRESS_BITS'(2);

	always_comb begin
		mode_d   = mode_q;
		pc_d     = pc_q;
		first_d  = first_q;
		second_d = second_q;
		skip_d   = skip_q;
		wv       = 1'b0;
		wa       = '0;
		wd       = '0;
		case (op)
			OP_VSYNC: begin
				if (dma_q) begin
					pc_d   = list1_q;
					mode_d = ST_REQ;
				end else begin
					mode_d = ST_HALT;
				end
			end
			OP_JUMP1: begin
				pc_d   = list1_q;
				mode_d = ST_REQ;
			end
			OP_JUMP2: begin
				pc_d   = list2_q;
				mode_d = ST_REQ;
			end
			OP_TICK: begin
				case (mode_q)
					ST_REQ: begin
						if (bus_free) mode_d = ST_FETCH;
					end
					ST_FETCH: begin
						if (bus_free) begin
							first_d = mem_word;
							pc_d    = pc_inc;
							mode_d  = mem_word[0] ? ST_WSKIP : ST_MOVE;
						end
					end
					ST_MOVE: begin
						if (bus_free) begin
							second_d = mem_word;
							pc_d     = pc_inc;
							if (move_ra[8] == 1'b0 && move_ra[7:0] < limit) begin
								mode_d = ST_HALT;
							end else begin
								if (!skip_q) begin
									wv = 1'b1;
									wa = move_ra;
									wd = mem_word;
								end
								skip_d = 1'b0;
								mode_d = ST_FETCH;
							end
						end
					end
					ST_WSKIP: begin
						if (bus_free) begin
							second_d = mem_word;
							pc_d     = pc_inc;
							if (!mem_word[0]) begin
								skip_d = 1'b0;
								mode_d = ST_WAITING;
							end else begin
								skip_d = reached;
								mode_d = ST_FETCH;
							end
						end
					end
					ST_WAITING: begin
						if (reached) mode_d = ST_REQ;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign pc_ext = EXT_W'(pc_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ST_HALT;
			pc_q     <= '0;
			first_q  <= '0;
			second_q <= '0;
			skip_q   <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pc_q     <= pc_d;
			first_q  <= first_d;
			second_q <= second_d;
			skip_q   <= skip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {7'b0, skip_d, mode_code(mode_d), pc_ext[PC_OUT_W-1:0], wd, wa, wv};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
